[hw/rtl/wavdac_pkg.sv]
package wavdac_pkg;

	// Parser phases
	localparam logic [2:0] PH_RIFF = 3'd0;
	localparam logic [2:0] PH_CHDR = 3'd1;
	localparam logic [2:0] PH_FMT  = 3'd2;
	localparam logic [2:0] PH_SKIP = 3'd3;
	localparam logic [2:0] PH_PAD  = 3'd4;
	localparam logic [2:0] PH_DATA = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;

	// Chunk tags, little-endian as they arrive on the byte stream
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Result kinds
	localparam logic [1:0] KIND_AUDIO  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NOT_WAVE = 2'd0;
	localparam logic [1:0] ERR_NOT_PCM  = 2'd1;
	localparam logic [1:0] ERR_NOT_16B  = 2'd2;
	localparam logic [1:0] ERR_MISSING  = 2'd3;

	localparam int OFF_W = 5;

	localparam logic [OFF_W-1:0] RIFF_HDR_LEN  = 5'd12;
	localparam logic [OFF_W-1:0] RIFF_LEN_OFF  = 5'd8;
	localparam logic [OFF_W-1:0] TAG_LEN       = 5'd4;
	localparam logic [OFF_W-1:0] CHUNK_HDR_LEN = 5'd8;
	localparam logic [OFF_W-1:0] FMT_LEN       = 5'd16;
	localparam logic [31:0]      FMT_MIN_LEN   = 32'd16;

	localparam logic [15:0] FMT_PCM       = 16'd1;
	localparam logic [15:0] FMT_BITS16    = 16'd16;
	localparam logic [15:0] CH_RESET      = 16'd1;
	localparam logic [31:0] RATE_RESET    = 32'd44100;

	localparam logic [16:0] GAIN_RESET    = 17'd32768;
	localparam logic [16:0] GAIN_MAX      = 17'd65536;
	localparam logic [15:0] DAC_MID       = 16'h8000;
	localparam logic signed [33:0] Q15_BIAS  = 34'sd32767;
	localparam logic signed [33:0] S16_MAX   = 34'sd32767;
	localparam logic signed [33:0] S16_MIN   = -34'sd32768;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sample;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [1:0]  err;
	} res_t;

endpackage

[hw/rtl/wavdac_parser.sv]
module wavdac_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              last_byte,
	output logic              res_valid,
	output wavdac_pkg::res_t  res
);
	import wavdac_pkg::*;

	logic [2:0]       phase_q, c_phase, nx_phase;
	logic [OFF_W-1:0] off_q, c_off, nx_off;
	logic [31:0]      len_q, c_len, nx_len;
	logic [31:0]      tag_q, c_tag, nx_tag;
	logic [31:0]      fs_q, c_fs, nx_fs;
	logic             fmt_seen_q, c_fmt_seen, nx_fmt_seen;
	logic [15:0]      ch_q, c_ch, nx_ch;
	logic [31:0]      rate_q, c_rate, nx_rate;
	logic [31:0]      pay_q, c_pay, nx_pay;
	logic [15:0]      fsamp_q, c_fsamp, nx_fsamp;
	logic [1:0]       fbi_q, c_fbi, nx_fbi;

	logic [4:0]  sh;
	logic [15:0] word;
	logic [16:0] sum;
	logic [16:0] sum_adj;

	always_comb begin
		// A first byte restarts parsing before the byte itself is used.
		c_phase    = first_byte ? PH_RIFF    : phase_q;
		c_off      = first_byte ? '0         : off_q;
		c_len      = first_byte ? '0         : len_q;
		c_tag      = first_byte ? '0         : tag_q;
		c_fs       = first_byte ? '0         : fs_q;
		c_fmt_seen = first_byte ? 1'b0       : fmt_seen_q;
		c_ch       = first_byte ? CH_RESET   : ch_q;
		c_rate     = first_byte ? RATE_RESET : rate_q;
		c_pay      = first_byte ? '0         : pay_q;
		c_fsamp    = first_byte ? '0         : fsamp_q;
		c_fbi      = first_byte ? '0         : fbi_q;

		nx_phase    = c_phase;
		nx_off      = c_off;
		nx_len      = c_len;
		nx_tag      = c_tag;
		nx_fs       = c_fs;
		nx_fmt_seen = c_fmt_seen;
		nx_ch       = c_ch;
		nx_rate     = c_rate;
		nx_pay      = c_pay;
		nx_fsamp    = c_fsamp;
		nx_fbi      = c_fbi;

		res_valid    = 1'b0;
		res          = '0;
		res.kind     = KIND_AUDIO;

		sh      = {c_off[1:0], 3'b000};
		word    = {data_byte, c_fs[7:0]};
		sum     = {c_fsamp[15], c_fsamp} + {word[15], word};
		sum_adj = sum + {16'd0, sum[16]};

		unique case (c_phase)
			PH_RIFF: begin
				if (c_off < TAG_LEN) begin
					nx_tag = c_tag | (32'(data_byte) << sh);
				end else if (c_off >= RIFF_LEN_OFF) begin
					nx_len = c_len | (32'(data_byte) << sh);
				end
				nx_off = c_off + 1'b1;
				if (nx_off >= RIFF_HDR_LEN) begin
					if (nx_tag == TAG_RIFF && nx_len == TAG_WAVE) begin
						nx_phase = PH_CHDR;
						nx_off   = '0;
						nx_tag   = '0;
						nx_len   = '0;
					end else begin
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_NOT_WAVE;
						nx_phase  = PH_DONE;
					end
				end
			end
			PH_CHDR: begin
				if (c_off < TAG_LEN) begin
					nx_tag = c_tag | (32'(data_byte) << sh);
				end else begin
					nx_len = c_len | (32'(data_byte) << sh);
				end
				nx_off = c_off + 1'b1;
				if (nx_off >= CHUNK_HDR_LEN) begin
					nx_off = '0;
					if (nx_tag == TAG_FMT && nx_len >= FMT_MIN_LEN) begin
						nx_phase = PH_FMT;
						nx_fs    = '0;
					end else if (nx_tag == TAG_DATA) begin
						res_valid = 1'b1;
						if (!c_fmt_seen) begin
							res.kind = KIND_ERROR;
							res.err  = ERR_MISSING;
							nx_phase = PH_DONE;
						end else begin
							res.kind     = KIND_HEADER;
							res.channels = c_ch;
							res.rate     = c_rate;
							nx_pay       = nx_len;
							nx_fbi       = '0;
							nx_phase     = (nx_len != '0) ? PH_DATA : PH_DONE;
						end
					end else begin
						nx_pay = nx_len;
						if (nx_len != '0) begin
							nx_phase = PH_SKIP;
						end else begin
							nx_phase = PH_CHDR;
							nx_tag   = '0;
							nx_len   = '0;
						end
					end
				end
			end
			PH_FMT: begin
				case (c_off[3:0])
					4'd0:  nx_fs          = {24'd0, data_byte};
					4'd1:  nx_fs[15:8]    = data_byte;
					4'd2:  nx_ch          = {8'd0, data_byte};
					4'd3:  nx_ch[15:8]    = data_byte;
					4'd4:  nx_rate        = {24'd0, data_byte};
					4'd5:  nx_rate[15:8]  = data_byte;
					4'd6:  nx_rate[23:16] = data_byte;
					4'd7:  nx_rate[31:24] = data_byte;
					4'd14: nx_fs[23:16]   = data_byte;
					4'd15: nx_fs[31:24]   = data_byte;
					default: ;
				endcase
				nx_off = c_off + 1'b1;
				if (nx_off >= FMT_LEN) begin
					nx_off = '0;
					if (nx_fs[15:0] != FMT_PCM) begin
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_NOT_PCM;
						nx_phase  = PH_DONE;
					end else if (nx_fs[31:16] != FMT_BITS16) begin
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_NOT_16B;
						nx_phase  = PH_DONE;
					end else begin
						nx_fmt_seen = 1'b1;
						nx_pay      = c_len - FMT_MIN_LEN;
						if (nx_pay != '0) begin
							nx_phase = PH_SKIP;
						end else if (c_len[0]) begin
							nx_phase = PH_PAD;
						end else begin
							nx_phase = PH_CHDR;
							nx_tag   = '0;
							nx_len   = '0;
						end
					end
				end
			end
			PH_SKIP: begin
				nx_pay = c_pay - 1'b1;
				if (nx_pay == '0) begin
					if (c_len[0]) begin
						nx_phase = PH_PAD;
					end else begin
						nx_phase = PH_CHDR;
						nx_off   = '0;
						nx_tag   = '0;
						nx_len   = '0;
					end
				end
			end
			PH_PAD: begin
				nx_phase = PH_CHDR;
				nx_off   = '0;
				nx_tag   = '0;
				nx_len   = '0;
			end
			PH_DATA: begin
				nx_pay = c_pay - 1'b1;
				case (c_fbi)
					2'd0: begin
						nx_fs  = {24'd0, data_byte};
						nx_fbi = 2'd1;
					end
					2'd1: begin
						if (c_ch == CH_RESET) begin
							res_valid  = 1'b1;
							res.sample = word;
							nx_fbi     = 2'd0;
						end else begin
							nx_fsamp = word;
							nx_fbi   = 2'd2;
						end
					end
					2'd2: begin
						nx_fs  = {24'd0, data_byte};
						nx_fbi = 2'd3;
					end
					default: begin
						// Stereo mix: average with truncation toward zero.
						res_valid  = 1'b1;
						res.sample = sum_adj[16:1];
						nx_fbi     = 2'd0;
					end
				endcase
				if (nx_pay == '0) begin
					nx_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		if (last_byte && nx_phase != PH_DONE) begin
			if (nx_phase == PH_DATA) begin
				nx_phase = PH_DONE;
			end else begin
				res_valid    = 1'b1;
				res.kind     = KIND_ERROR;
				res.sample   = '0;
				res.channels = '0;
				res.rate     = '0;
				res.err      = (nx_phase == PH_RIFF) ? ERR_NOT_WAVE : ERR_MISSING;
				nx_phase     = PH_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			off_q      <= '0;
			len_q      <= '0;
			tag_q      <= '0;
			fs_q       <= '0;
			fmt_seen_q <= 1'b0;
			ch_q       <= CH_RESET;
			rate_q     <= RATE_RESET;
			pay_q      <= '0;
			fsamp_q    <= '0;
			fbi_q      <= '0;
		end else if (go) begin
			phase_q    <= nx_phase;
			off_q      <= nx_off;
			len_q      <= nx_len;
			tag_q      <= nx_tag;
			fs_q       <= nx_fs;
			fmt_seen_q <= nx_fmt_seen;
			ch_q       <= nx_ch;
			rate_q     <= nx_rate;
			pay_q      <= nx_pay;
			fsamp_q    <= nx_fsamp;
			fbi_q      <= nx_fbi;
		end
	end

`ifndef SYNTHESIS
	a_fmt_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FMT |-> len_q >= FMT_MIN_LEN)
		else $error("fmt body entered with a short chunk length");

	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP || phase_q == PH_DATA) |-> pay_q != '0)
		else $error("body phase with no bytes left");

	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHDR |-> off_q < CHUNK_HDR_LEN)
		else $error("chunk header offset out of range");
`endif

endmodule

[hw/rtl/wavdac_scaler.sv]
module wavdac_scaler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [16:0]       cfg_wdata,
	input  logic              load,
	input  wavdac_pkg::res_t  res,
	output logic [1:0]        kind,
	output logic [15:0]       left_out,
	output logic [15:0]       right_out,
	output logic [15:0]       channel_count,
	output logic [31:0]       rate_hz,
	output logic [1:0]        error_code
);
	import wavdac_pkg::*;

	logic [16:0]        gain_q;
	logic [16:0]        gain_c;
	logic signed [15:0] smp;
	logic signed [17:0] gs;
	logic signed [33:0] prod;
	logic signed [33:0] quo;
	logic [15:0]        clip;
	logic [15:0]        dac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	always_comb begin
		gain_c = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
		smp    = $signed(res.sample);
		gs     = $signed({1'b0, gain_c});
		prod   = 34'(smp) * 34'(gs);
		// Divide by 32768 with truncation toward zero: bias negatives first.
		quo    = (prod + (prod[33] ? Q15_BIAS : 34'sd0)) >>> 15;
		if (quo > S16_MAX) begin
			clip = 16'h7FFF;
		end else if (quo < S16_MIN) begin
			clip = 16'h8000;
		end else begin
			clip = quo[15:0];
		end
		dac = clip ^ DAC_MID;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind          <= res.kind;
			left_out      <= (res.kind == KIND_AUDIO) ? dac : DAC_MID;
			right_out     <= (res.kind == KIND_AUDIO) ? dac : DAC_MID;
			channel_count <= res.channels;
			rate_hz       <= res.rate;
			error_code    <= res.err;
		end
	end

endmodule

[hw/rtl/wav_pcm16_stream_to_dac_frames_top.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    data_byte, first_byte, last_byte
// out       source     out_valid/out_ready  kind, left_out, right_out,
//                                           channel_count, rate_hz, error_code
// cfg       sink       cfg_we (no wait)     cfg_wdata (playback gain)
//
// One byte is accepted per cycle when the output side keeps up.
// A request passes an input register, the chunk parser into a result register,
// and the scaler's multiply and clip into the output register, which drives
// out_valid; bytes that give no result stop at the parser.
// Reset clears the parse state and sets the gain to unity.
// A stalled output register backs up through the stages; in_ready drops only
// when all three stages hold a request.
module wav_pcm16_stream_to_dac_frames_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] left_out,
	output logic [15:0] right_out,
	output logic [15:0] channel_count,
	output logic [31:0] rate_hz,
	output logic [1:0]  error_code,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);
	import wavdac_pkg::*;

	logic       v_s1, v_s2, v_s3;
	logic [7:0] byte_s1;
	logic       first_s1, last_s1;
	res_t       res_nx, res_s2;
	logic       res_nx_valid;
	logic       s3_free, s2_free, s1_go, s3_load;

	assign s3_free  = !v_s3 || out_ready;
	assign s2_free  = !v_s2 || s3_free;
	assign s1_go    = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;
	assign s3_load  = v_s2 && s3_free;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			// Bytes that give no result leave no bubble-holding entry behind.
			if (s2_free) begin
				v_s2 <= s1_go && res_nx_valid;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
		if (s1_go) begin
			res_s2 <= res_nx;
		end
	end

	wavdac_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (s1_go),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.res_valid  (res_nx_valid),
		.res        (res_nx)
	);

	wavdac_scaler u_scaler (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.load          (s3_load),
		.res           (res_s2),
		.kind          (kind),
		.left_out      (left_out),
		.right_out     (right_out),
		.channel_count (channel_count),
		.rate_hz       (rate_hz),
		.error_code    (error_code)
	);

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_free |=> v_s1)
		else $error("input stage dropped a stalled request");

	a_audio_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_AUDIO |->
			channel_count == '0 && rate_hz == '0 && error_code == '0)
		else $error("audio frame carries header or error fields");

	a_header_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_AUDIO |-> left_out == DAC_MID && right_out == DAC_MID)
		else $error("non-audio result with non-silent samples");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !s3_free |=> v_s2)
		else $error("result stage lost a request under stall");
`endif

endmodule
